>>> rtl/core/linked_list_queue_with_free_list_unit_defines.svh
// Assertion helpers; each expects clk and rst_n in scope.
`ifndef LINKED_LIST_QUEUE_WITH_FREE_LIST_UNIT_DEFINES_SVH
`define LINKED_LIST_QUEUE_WITH_FREE_LIST_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define LLQ_ASSERT_IMPL(name, cond, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
    else $error("llq assertion failed");
`define LLQ_ASSERT_NEXT(name, cond, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error("llq assertion failed");
`else
`define LLQ_ASSERT_IMPL(name, cond, prop)
`define LLQ_ASSERT_NEXT(name, cond, prop)
`endif

`endif

>>> rtl/core/llq_pkg.sv
`timescale 1ns / 1ps
package llq_pkg;

  localparam logic [1:0] OP_PUSH = 2'd0;
  localparam logic [1:0] OP_POP  = 2'd1;
  localparam logic [1:0] OP_PEEK = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_OVERFLOW  = 2'd1;
  localparam logic [1:0] ST_UNDERFLOW = 2'd2;

  typedef struct packed {
    logic [1:0]         opcode;
    logic signed [31:0] item_value;
  } in_req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] front_value;
    logic signed [31:0] rear_value;
    logic [4:0]         occupancy;
    logic               is_empty;
    logic               is_full;
  } out_rsp_t;

  typedef struct packed {
    logic       done;
    logic [1:0] status;
  } llq_evt_t;

endpackage

>>> rtl/core/linked_list_queue_with_free_list_unit.sv
`timescale 1ns / 1ps
// Linked-list FIFO with a free list of slots.
// Input: a request (in_req: opcode, item_value) is taken on a rising edge with
// start high and busy low. Push enqueues, pop dequeues, any other code peeks.
// Output: one response per request, on out_rsp for exactly one cycle while
// out_valid is high. It carries the status, front and rear values (-1 when
// empty), occupancy and the empty and full flags after the request.
// Sequencing: push, peek, and a pop that empties the queue pass from accept
// through the link state; a pop that leaves elements also passes the data
// state. The link state uses the link memory read of the new head pointer
// (or next free slot), then, on pop, the data memory read of the new front
// value. The response appears in the cycle after the last update, the same
// cycle in which the next request may be taken.
// Reset: synchronous, active low. The queue comes up empty with every slot
// free; no memory sweep is needed, slots never used are handed out in order.
// The receiver cannot stall: every response is shown once and must be taken.
module linked_list_queue_with_free_list_unit import llq_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 16,
  parameter int unsigned DATA_WIDTH  = 32
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  in_req_t  in_req,
  output logic     out_valid,
  output out_rsp_t out_rsp
);

  localparam int unsigned IW = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned AW = $clog2(QUEUE_DEPTH);
  localparam logic [IW-1:0] FULL_CNT = IW'(QUEUE_DEPTH);

  llq_evt_t              evt;
  logic [DATA_WIDTH-1:0] front_data;
  logic [DATA_WIDTH-1:0] rear_data;
  logic [IW-1:0]         count;
  logic                  data_we;
  logic [AW-1:0]         data_waddr;
  logic [DATA_WIDTH-1:0] data_wdata;
  logic [AW-1:0]         data_raddr;
  logic [DATA_WIDTH-1:0] data_rdata;
  logic                  link_we;
  logic [AW-1:0]         link_waddr;
  logic [IW-1:0]         link_wdata;
  logic [AW-1:0]         link_raddr;
  logic [IW-1:0]         link_rdata;

  logic     out_valid_r;
  out_rsp_t out_rsp_r, out_rsp_nxt;
  logic     empty;

  llq_ctrl #(
    .DEPTH (QUEUE_DEPTH),
    .DW    (DATA_WIDTH),
    .IW    (IW),
    .AW    (AW)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .req        (in_req),
    .evt        (evt),
    .front_data (front_data),
    .rear_data  (rear_data),
    .count      (count),
    .data_we    (data_we),
    .data_waddr (data_waddr),
    .data_wdata (data_wdata),
    .data_raddr (data_raddr),
    .data_rdata (data_rdata),
    .link_we    (link_we),
    .link_waddr (link_waddr),
    .link_wdata (link_wdata),
    .link_raddr (link_raddr),
    .link_rdata (link_rdata)
  );

  llq_store #(
    .DEPTH (QUEUE_DEPTH),
    .DW    (DATA_WIDTH),
    .IW    (IW),
    .AW    (AW)
  ) u_store (
    .clk        (clk),
    .data_we    (data_we),
    .data_waddr (data_waddr),
    .data_wdata (data_wdata),
    .data_raddr (data_raddr),
    .data_rdata (data_rdata),
    .link_we    (link_we),
    .link_waddr (link_waddr),
    .link_wdata (link_wdata),
    .link_raddr (link_raddr),
    .link_rdata (link_rdata)
  );

  assign empty = (count == '0);

  always_comb begin
    out_rsp_nxt.status      = evt.status;
    out_rsp_nxt.front_value = empty ? '1 : 32'(signed'(front_data));
    out_rsp_nxt.rear_value  = empty ? '1 : 32'(signed'(rear_data));
    out_rsp_nxt.occupancy   = 5'(count);
    out_rsp_nxt.is_empty    = empty;
    out_rsp_nxt.is_full     = (count == FULL_CNT);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= evt.done;
    end
  end

  always_ff @(posedge clk) begin
    if (evt.done) begin
      out_rsp_r <= out_rsp_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

endmodule

>>> rtl/core/llq_store.sv
`timescale 1ns / 1ps
module llq_store #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned DW    = 32,
  parameter int unsigned IW    = 5,
  parameter int unsigned AW    = 4
) (
  input  logic          clk,
  input  logic          data_we,
  input  logic [AW-1:0] data_waddr,
  input  logic [DW-1:0] data_wdata,
  input  logic [AW-1:0] data_raddr,
  output logic [DW-1:0] data_rdata,
  input  logic          link_we,
  input  logic [AW-1:0] link_waddr,
  input  logic [IW-1:0] link_wdata,
  input  logic [AW-1:0] link_raddr,
  output logic [IW-1:0] link_rdata
);

  logic [DW-1:0] data_mem [DEPTH];
  logic [IW-1:0] link_mem [DEPTH];

  always_ff @(posedge clk) begin
    if (data_we) begin
      data_mem[data_waddr] <= data_wdata;
    end
    data_rdata <= data_mem[data_raddr];
  end

  always_ff @(posedge clk) begin
    if (link_we) begin
      link_mem[link_waddr] <= link_wdata;
    end
    link_rdata <= link_mem[link_raddr];
  end

endmodule

>>> rtl/core/llq_ctrl.sv
`timescale 1ns / 1ps
`include "linked_list_queue_with_free_list_unit_defines.svh"
module llq_ctrl import llq_pkg::*; #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned DW    = 32,
  parameter int unsigned IW    = 5,
  parameter int unsigned AW    = 4
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  in_req_t       req,
  output llq_evt_t      evt,
  output logic [DW-1:0] front_data,
  output logic [DW-1:0] rear_data,
  output logic [IW-1:0] count,
  output logic          data_we,
  output logic [AW-1:0] data_waddr,
  output logic [DW-1:0] data_wdata,
  output logic [AW-1:0] data_raddr,
  input  logic [DW-1:0] data_rdata,
  output logic          link_we,
  output logic [AW-1:0] link_waddr,
  output logic [IW-1:0] link_wdata,
  output logic [AW-1:0] link_raddr,
  input  logic [IW-1:0] link_rdata
);

  localparam logic [IW-1:0] NULL_IDX = IW'(DEPTH);

  typedef enum logic [1:0] {S_IDLE, S_LINK, S_DATA} state_t;

  state_t        state_r, state_nxt;
  logic [1:0]    op_r, op_nxt;
  logic [DW-1:0] value_r, value_nxt;
  logic [IW-1:0] head_r, head_nxt;
  logic [IW-1:0] tail_r, tail_nxt;
  logic [IW-1:0] free_r, free_nxt;
  logic [IW-1:0] fresh_r, fresh_nxt;
  logic [IW-1:0] count_r, count_nxt;
  logic [DW-1:0] front_r, front_nxt;
  logic [DW-1:0] rear_r, rear_nxt;

  assign busy       = (state_r != S_IDLE);
  assign front_data = front_nxt;
  assign rear_data  = rear_nxt;
  assign count      = count_nxt;

  always_comb begin
    state_nxt  = state_r;
    op_nxt     = op_r;
    value_nxt  = value_r;
    head_nxt   = head_r;
    tail_nxt   = tail_r;
    free_nxt   = free_r;
    fresh_nxt  = fresh_r;
    count_nxt  = count_r;
    front_nxt  = front_r;
    rear_nxt   = rear_r;
    evt        = '0;
    data_we    = 1'b0;
    data_waddr = free_r[AW-1:0];
    data_wdata = value_r;
    data_raddr = link_rdata[AW-1:0];
    link_we    = 1'b0;
    link_waddr = tail_r[AW-1:0];
    link_wdata = free_r;
    link_raddr = (req.opcode == OP_PUSH) ? free_r[AW-1:0] : head_r[AW-1:0];
    case (state_r)
      S_IDLE: begin
        if (start) begin
          op_nxt    = req.opcode;
          value_nxt = DW'(req.item_value);
          state_nxt = S_LINK;
        end
      end
      S_LINK: begin
        state_nxt  = S_IDLE;
        evt.done   = 1'b1;
        evt.status = ST_OK;
        case (op_r)
          OP_PUSH: begin
            if (count_r == NULL_IDX) begin
              evt.status = ST_OVERFLOW;
            end else begin
              data_we = 1'b1;
              if (count_r != '0) begin
                link_we = 1'b1;
              end else begin
                head_nxt  = free_r;
                front_nxt = value_r;
              end
              tail_nxt = free_r;
              rear_nxt = value_r;
              if (free_r == fresh_r) begin
                free_nxt  = fresh_r + 1'b1;
                fresh_nxt = fresh_r + 1'b1;
              end else begin
                free_nxt = link_rdata;
              end
              count_nxt = count_r + 1'b1;
            end
          end
          OP_POP: begin
            if (count_r == '0) begin
              evt.status = ST_UNDERFLOW;
            end else begin
              link_we    = 1'b1;
              link_waddr = head_r[AW-1:0];
              free_nxt   = head_r;
              count_nxt  = count_r - 1'b1;
              if (head_r == tail_r) begin
                head_nxt = NULL_IDX;
                tail_nxt = NULL_IDX;
              end else begin
                head_nxt  = link_rdata;
                evt.done  = 1'b0;
                state_nxt = S_DATA;
              end
            end
          end
          OP_PEEK: begin
          end
          default: begin
          end
        endcase
      end
      S_DATA: begin
        front_nxt  = data_rdata;
        evt.done   = 1'b1;
        evt.status = ST_OK;
        state_nxt  = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      head_r  <= NULL_IDX;
      tail_r  <= NULL_IDX;
      free_r  <= '0;
      fresh_r <= '0;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      free_r  <= free_nxt;
      fresh_r <= fresh_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r    <= op_nxt;
    value_r <= value_nxt;
    front_r <= front_nxt;
    rear_r  <= rear_nxt;
  end

  `LLQ_ASSERT_IMPL(a_empty_head, 1'b1, (count_r == '0) == (head_r == NULL_IDX))
  `LLQ_ASSERT_IMPL(a_free_fresh, 1'b1, (free_r <= fresh_r) || (free_r == NULL_IDX))
  `LLQ_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
  `LLQ_ASSERT_NEXT(a_push_count, (state_r == S_LINK) && (op_r == OP_PUSH) && (count_r != NULL_IDX), count_r == $past(count_r) + 1'b1)
  `LLQ_ASSERT_IMPL(a_done_busy, evt.done, state_r != S_IDLE)

endmodule

>>> tb/linked_list_queue_with_free_list_unit_checker.sv
`timescale 1ns / 1ps
module linked_list_queue_with_free_list_unit_checker import llq_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  input  logic     busy,
  input  in_req_t  in_req,
  input  logic     out_valid,
  input  out_rsp_t out_rsp,
  output int       fail_count,
  output int       pending
);

  localparam int         DEPTH     = 16;
  localparam logic [4:0] NULL_SLOT = 5'd16;

  logic signed [31:0] slot_data [DEPTH];
  logic [4:0]         slot_link [DEPTH];
  logic [4:0]         free_ptr;
  logic [4:0]         head_ptr;
  logic [4:0]         tail_ptr;
  logic [4:0]         elem_count;

  out_rsp_t expected_rsp_q [$];
  int       mismatches = 0;
  int       rsp_seen   = 0;

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("[%0t] response %0d: %s got %h expected %h", $time, rsp_seen, what, got, want);
    mismatches++;
  endtask

  task automatic clear_queue_state();
    for (int i = 0; i < DEPTH; i++) begin
      slot_data[i] = '0;
      slot_link[i] = 5'(i + 1);
    end
    free_ptr   = '0;
    head_ptr   = NULL_SLOT;
    tail_ptr   = NULL_SLOT;
    elem_count = '0;
  endtask

  function automatic out_rsp_t apply_queue_op(in_req_t req);
    out_rsp_t   rsp;
    logic [4:0] slot;
    rsp        = '0;
    rsp.status = ST_OK;
    case (req.opcode)
      OP_PUSH: begin
        if (free_ptr == NULL_SLOT) begin
          rsp.status = ST_OVERFLOW;
        end else begin
          slot                 = free_ptr;
          free_ptr             = slot_link[slot[3:0]];
          slot_data[slot[3:0]] = req.item_value;
          slot_link[slot[3:0]] = NULL_SLOT;
          if (head_ptr != NULL_SLOT && tail_ptr != NULL_SLOT) begin
            slot_link[tail_ptr[3:0]] = slot;
          end else begin
            head_ptr = slot;
          end
          tail_ptr   = slot;
          elem_count = elem_count + 5'd1;
        end
      end
      OP_POP: begin
        if (head_ptr == NULL_SLOT) begin
          rsp.status = ST_UNDERFLOW;
        end else begin
          slot = head_ptr;
          if (slot == tail_ptr) begin
            head_ptr = NULL_SLOT;
            tail_ptr = NULL_SLOT;
          end else begin
            head_ptr = slot_link[slot[3:0]];
          end
          slot_link[slot[3:0]] = free_ptr;
          free_ptr             = slot;
          if (elem_count != 0) elem_count = elem_count - 5'd1;
        end
      end
      default: ;
    endcase
    rsp.is_empty    = (head_ptr == NULL_SLOT);
    rsp.front_value = rsp.is_empty ? -32'sd1 : slot_data[head_ptr[3:0]];
    rsp.rear_value  = rsp.is_empty ? -32'sd1 : slot_data[tail_ptr[3:0]];
    rsp.occupancy   = elem_count;
    rsp.is_full     = (elem_count == 5'(DEPTH));
    return rsp;
  endfunction

  always @(posedge clk) begin
    out_rsp_t want;
    if (!rst_n) begin
      clear_queue_state();
      expected_rsp_q.delete();
    end else begin
      if (out_valid) begin
        if (expected_rsp_q.size() == 0) begin
          report_mismatch("unexpected response, status", 32'(out_rsp.status), 32'hx);
        end else begin
          want = expected_rsp_q.pop_front();
          if (out_rsp.status !== want.status)
            report_mismatch("status", 32'(out_rsp.status), 32'(want.status));
          if (out_rsp.front_value !== want.front_value)
            report_mismatch("front_value", out_rsp.front_value, want.front_value);
          if (out_rsp.rear_value !== want.rear_value)
            report_mismatch("rear_value", out_rsp.rear_value, want.rear_value);
          if (out_rsp.occupancy !== want.occupancy)
            report_mismatch("occupancy", 32'(out_rsp.occupancy), 32'(want.occupancy));
          if (out_rsp.is_empty !== want.is_empty)
            report_mismatch("is_empty", 32'(out_rsp.is_empty), 32'(want.is_empty));
          if (out_rsp.is_full !== want.is_full)
            report_mismatch("is_full", 32'(out_rsp.is_full), 32'(want.is_full));
        end
        rsp_seen++;
      end
      if (start && !busy) expected_rsp_q.push_back(apply_queue_op(in_req));
    end
    fail_count <= mismatches;
    pending    <= expected_rsp_q.size();
  end

endmodule

>>> tb/linked_list_queue_with_free_list_unit_tb.sv
`timescale 1ns / 1ps
module linked_list_queue_with_free_list_unit_tb;
  import llq_pkg::*;

  localparam int         DEPTH     = 16;
  localparam int         RAND_REQS = 1050;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  logic     clk;
  logic     rst_n;
  logic     start;
  logic     busy;
  in_req_t  in_req;
  logic     out_valid;
  out_rsp_t out_rsp;
  int       fail_count;
  int       pending;

  int level      = 0;
  int n_push     = 0;
  int n_pop      = 0;
  int n_peek     = 0;
  int n_overflow = 0;
  int n_under    = 0;
  bit draining   = 1'b0;

  linked_list_queue_with_free_list_unit #(
    .QUEUE_DEPTH(DEPTH),
    .DATA_WIDTH (32)
  ) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_req   (in_req),
    .out_valid(out_valid),
    .out_rsp  (out_rsp)
  );

  linked_list_queue_with_free_list_unit_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_rsp   (out_rsp),
    .fail_count(fail_count),
    .pending   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #200000;
    $display("timeout with %0d responses outstanding", pending);
    $display("[linked_list_queue_with_free_list_unit] ERROR");
    $finish;
  end

  function automatic logic [31:0] pick_value();
    case ($urandom_range(11))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return 32'h0000_0000;
      3:       return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  task automatic issue_req(input logic [1:0] op, input logic [31:0] val, input bit gaps);
    if (gaps) begin
      while ($urandom_range(99) < 20) begin
        start <= 1'b0;
        @(posedge clk);
      end
    end
    start              <= 1'b1;
    in_req.opcode      <= op;
    in_req.item_value  <= val;
    do @(posedge clk); while (busy);
    case (op)
      OP_PUSH: begin
        n_push++;
        if (level < DEPTH) level++;
        else n_overflow++;
      end
      OP_POP: begin
        n_pop++;
        if (level > 0) level--;
        else n_under++;
      end
      default: n_peek++;
    endcase
  endtask

  initial begin
    int r;
    int push_pct;
    rst_n  <= 1'b0;
    start  <= 1'b0;
    in_req <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty queue: peek, underflow, unused code
    issue_req(OP_PEEK, 32'h1234_5678, 1'b1);
    issue_req(OP_POP, 32'hdead_beef, 1'b1);
    issue_req(OP_UNUSED, 32'hffff_ffff, 1'b1);
    // single element, then pop the last one
    issue_req(OP_PUSH, 32'h8000_0000, 1'b1);
    issue_req(OP_PEEK, 32'h0, 1'b1);
    issue_req(OP_POP, 32'h0, 1'b1);
    // fill to full with extremes first, then overflow
    issue_req(OP_PUSH, 32'h7fff_ffff, 1'b1);
    issue_req(OP_PUSH, 32'h0000_0000, 1'b1);
    issue_req(OP_PUSH, 32'hffff_ffff, 1'b1);
    while (level < DEPTH) issue_req(OP_PUSH, pick_value(), 1'b1);
    issue_req(OP_PUSH, 32'h5555_aaaa, 1'b1);
    issue_req(OP_UNUSED, 32'h0, 1'b1);

    // sweep occupancy between empty and full
    draining = 1'b1;
    for (int i = 0; i < RAND_REQS; i++) begin
      if (draining && level == 0 && $urandom_range(3) == 0) draining = 1'b0;
      else if (!draining && level == DEPTH && $urandom_range(3) == 0) draining = 1'b1;
      else if ($urandom_range(39) == 0) draining = !draining;
      push_pct = draining ? 25 : 65;
      r = $urandom_range(99);
      if (r < push_pct)   issue_req(OP_PUSH, pick_value(), !(i >= 400 && i < 650));
      else if (r < 85)    issue_req(OP_POP, $urandom, !(i >= 400 && i < 650));
      else if (r < 95)    issue_req(OP_PEEK, $urandom, !(i >= 400 && i < 650));
      else                issue_req(OP_UNUSED, $urandom, !(i >= 400 && i < 650));
    end
    start <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("requests: %0d push, %0d pop, %0d peek or unused code", n_push, n_pop, n_peek);
    $display("push on full queue %0d times, pop on empty queue %0d times",
             n_overflow, n_under);
    if (fail_count == 0) begin
      $display("[linked_list_queue_with_free_list_unit] OK");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("[linked_list_queue_with_free_list_unit] ERROR");
    end
    $finish;
  end

endmodule

>>> linked_list_queue_with_free_list_unit.f
+incdir+rtl/core
rtl/core/llq_pkg.sv
rtl/core/llq_store.sv
rtl/core/llq_ctrl.sv
rtl/core/linked_list_queue_with_free_list_unit.sv
tb/linked_list_queue_with_free_list_unit_checker.sv
tb/linked_list_queue_with_free_list_unit_tb.sv
